// ----- rtl/core/etns_pkg.sv -----
package etns_pkg;

   localparam int NODE_WIDTH_DEFAULT  = 16;
   localparam int TABLE_DEPTH_DEFAULT = 32;
   localparam int MAX_RESULTS         = 32;
   localparam int ROOT_NODE           = 1;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLOSE
   } state_type;

endpackage

// ----- rtl/core/edge_table_neighbor_search.sv -----
// Load: writes one entry, no result. Query: accepted, then one entry scanned per cycle
// (table memory read, one port), then a close state in which the next transfer may be
// accepted. A match is held until the next match or the close and leaves the cycle
// after; the final result, with rsp_last set, is registered from the close state.
// Synchronous active-high reset clears control and entries_in_use; table undefined.
module edge_table_neighbor_search
   import etns_pkg::*;
#(
   parameter int NODE_WIDTH  = NODE_WIDTH_DEFAULT,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [4:0]  req_entry_index,
   input  logic [15:0] req_entry_source,
   input  logic [15:0] req_entry_dest,
   input  logic [1:0]  req_entry_relation,
   input  logic [15:0] req_query_node,
   input  logic [1:0]  req_query_relation,
   input  logic        req_search_parent,
   output logic        rsp_strobe,
   output logic [15:0] rsp_found_node,
   output logic        rsp_match_valid,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int EW = 2 * NODE_WIDTH + 2;
   localparam int CW = $clog2(MAX_RESULTS + 1);

   // entry layout: {source, dest, relation}
   logic [EW-1:0] edge_table_mem [TABLE_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic [IW-1:0] rd_addr;

   state_type state_ff, state_in;
   logic [5:0]            entries_in_use_ff;
   logic [IW-1:0]         idx_ff, idx_in, last_idx_ff, last_idx_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [NODE_WIDTH-1:0] q_node_ff, q_node_in;
   logic [1:0]            q_rel_ff, q_rel_in;
   logic                  q_parent_ff, q_parent_in;
   logic [NODE_WIDTH-1:0] pend_node_ff, pend_node_in;
   logic                  pend_valid_ff, pend_valid_in;

   logic                  out_strobe_ff, out_strobe_in;
   logic [15:0]           out_node_ff, out_node_in;
   logic                  out_match_ff, out_match_in;
   logic                  out_last_ff, out_last_in;

   logic                  accept, load_wr;
   logic [NODE_WIDTH+15:0] src_ext, dst_ext, qn_ext, pend_ext;
   logic [NODE_WIDTH-1:0] e_src, e_dst, e_key, e_other, qn_w;
   logic [1:0]            e_rel;
   logic                  hit;
   logic [6:0]            scan_sat;

   assign busy   = (state_ff == ST_SCAN);
   assign accept = start && !busy;

   assign src_ext = {{NODE_WIDTH{1'b0}}, req_entry_source};
   assign dst_ext = {{NODE_WIDTH{1'b0}}, req_entry_dest};
   assign qn_ext  = {{NODE_WIDTH{1'b0}}, req_query_node};
   assign qn_w    = qn_ext[NODE_WIDTH-1:0];

   assign load_wr = accept && (req_mode == MODE_LOAD)
                    && (7'(req_entry_index) < 7'(TABLE_DEPTH));

   assign scan_sat = ({1'b0, entries_in_use_ff} > 7'(TABLE_DEPTH)) ?
                     7'(TABLE_DEPTH) : {1'b0, entries_in_use_ff};

   assign rd_addr = (state_ff == ST_SCAN) ? IW'(idx_ff + 1'b1) : '0;

   assign e_src   = rd_data_ff[EW-1 -: NODE_WIDTH];
   assign e_dst   = rd_data_ff[NODE_WIDTH+1 -: NODE_WIDTH];
   assign e_rel   = rd_data_ff[1:0];
   assign e_key   = q_parent_ff ? e_dst : e_src;
   assign e_other = q_parent_ff ? e_src : e_dst;
   assign hit     = (e_key == q_node_ff) && (e_rel == q_rel_ff);

   assign pend_ext = {16'b0, pend_node_ff};

   always_ff @(posedge clock) begin
      if (load_wr) begin
         edge_table_mem[IW'(req_entry_index)] <= {src_ext[NODE_WIDTH-1:0],
                                                 dst_ext[NODE_WIDTH-1:0],
                                                 req_entry_relation};
      end
      rd_data_ff <= edge_table_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      last_idx_in   = last_idx_ff;
      cnt_in        = cnt_ff;
      q_node_in     = q_node_ff;
      q_rel_in      = q_rel_ff;
      q_parent_in   = q_parent_ff;
      pend_node_in  = pend_node_ff;
      pend_valid_in = pend_valid_ff;
      out_strobe_in = 1'b0;
      out_node_in   = out_node_ff;
      out_match_in  = out_match_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
         end
         ST_SCAN: begin
            idx_in = IW'(idx_ff + 1'b1);
            if (hit) begin
               if (pend_valid_ff) begin
                  out_strobe_in = 1'b1;
                  out_node_in   = pend_ext[15:0];
                  out_match_in  = 1'b1;
                  out_last_in   = 1'b0;
               end
               pend_node_in  = e_other;
               pend_valid_in = 1'b1;
               cnt_in        = CW'(cnt_ff + 1'b1);
            end
            // stop at the end of the used range or once the result cap is hit
            if (idx_ff == last_idx_ff
                || (hit && (cnt_ff == CW'(MAX_RESULTS - 1)))) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            out_strobe_in = 1'b1;
            out_node_in   = pend_valid_ff ? pend_ext[15:0] : 16'b0;
            out_match_in  = pend_valid_ff;
            out_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a new transfer may overlap the closing cycle
      if (accept && (req_mode == MODE_QUERY)) begin
         q_node_in     = qn_w;
         q_rel_in      = req_query_relation;
         q_parent_in   = req_search_parent;
         idx_in        = '0;
         last_idx_in   = IW'(scan_sat - 7'd1);
         cnt_in        = '0;
         pend_valid_in = 1'b0;
         if ((req_search_parent && (qn_w == NODE_WIDTH'(ROOT_NODE)))
             || (scan_sat == 7'd0)) begin
            state_in = ST_CLOSE;
         end else begin
            state_in = ST_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         entries_in_use_ff <= '0;
         out_strobe_ff     <= 1'b0;
         pend_valid_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_strobe_ff <= out_strobe_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_we) begin
            entries_in_use_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      last_idx_ff  <= last_idx_in;
      cnt_ff       <= cnt_in;
      q_node_ff    <= q_node_in;
      q_rel_ff     <= q_rel_in;
      q_parent_ff  <= q_parent_in;
      pend_node_ff <= pend_node_in;
      out_node_ff  <= out_node_in;
      out_match_ff <= out_match_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_strobe      = out_strobe_ff;
   assign rsp_found_node  = out_node_ff;
   assign rsp_match_valid = out_match_ff;
   assign rsp_last        = out_last_ff;

endmodule
